// ===== src/saers_pkg.sv =====
// Package for the sorted-array equal-range search block.
// Holds op and status codes, field widths and the command type shared by
// the front queue and the search engine. No dependencies.
package saers_pkg;

    localparam int OP_W    = 2;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_QUERY,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

endpackage

// ===== src/sorted_array_equal_range_search.sv =====
// Top level of the sorted-array equal-range search block.
// Connects the front queue (saers_front) to the search engine (saers_back).
// Uses saers_pkg.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | s_valid s_ready s_op s_value            | in
//   result  | m_valid m_ready m_status m_first_index  | out
//           | m_last_index                            |
//
// Append, clear and unused ops complete in the idle state. A query runs the
// lower-bound search (S_LOWER), an equality check (S_CHECK) that ends it
// when no element matches, and the upper-bound search (S_UPPER), with one
// RAM read per probe.
// The front queue holds two transfers, so input is still accepted until it is
// full while the result register waits on m_ready. Reset empties the store (count to zero).
module sorted_array_equal_range_search
    import saers_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic signed [DATA_W-1:0]  s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [INDEX_W-1:0]        m_first_index,
    output logic [INDEX_W-1:0]        m_last_index
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    saers_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_value   (s_value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    saers_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_first_index (m_first_index),
        .m_last_index  (m_last_index)
    );

endmodule

// ===== src/saers_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module saers_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/saers_front.sv =====
// Front end: accepts input transfers, decodes the op into a command kind
// and buffers commands in a short queue for the search engine. Uses saers_pkg.
module saers_front
    import saers_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic signed [DATA_W-1:0]  s_value,
    output logic                      cmd_valid,
    output cmd_t                      cmd,
    input  logic                      cmd_pop
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              push;
    logic              pop;
    cmd_t              cmd_in;

    always_comb begin
        cmd_in.value = s_value;
        unique case (s_op)
            OP_APPEND: cmd_in.kind = CMD_APPEND;
            OP_QUERY:  cmd_in.kind = CMD_QUERY;
            OP_CLEAR:  cmd_in.kind = CMD_CLEAR;
            default:   cmd_in.kind = CMD_NOP;
        endcase
    end

    assign s_ready   = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/saers_back.sv =====
// Search engine: executes appends and clears, runs the lower- and
// upper-bound binary searches over the element RAM, and holds the result
// register. Uses saers_pkg and saers_ram.
module saers_back
    import saers_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [INDEX_W-1:0]   m_first_index,
    output logic [INDEX_W-1:0]   m_last_index
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEPTH_C = CNT_W'(STORE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOWER,
        S_CHECK,
        S_UPPER
    } state_t;

    state_t                    state_reg, state_next;
    cnt_t                      lo_reg, lo_next;
    cnt_t                      hi_reg, hi_next;
    cnt_t                      mid_reg, mid_next;
    cnt_t                      count_reg, count_next;
    cnt_t                      first_reg, first_next;
    logic signed [DATA_W-1:0]  target_reg, target_next;
    logic                      m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [INDEX_W-1:0]        first_idx_reg, first_idx_next;
    logic [INDEX_W-1:0]        last_idx_reg, last_idx_next;

    logic                      out_free;
    logic                      ram_we;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  elem;
    cnt_t                      lo_c;
    cnt_t                      hi_c;

    function automatic cnt_t mid_of(input cnt_t lo, input cnt_t hi);
        cnt_t span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

    function automatic logic [INDEX_W-1:0] to_index(input cnt_t v);
        logic [CNT_W+INDEX_W-1:0] w;
        w = {{INDEX_W{1'b0}}, v};
        return w[INDEX_W-1:0];
    endfunction

    saers_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (cmd.value),
        .raddr (mid_next[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign elem     = ram_rdata;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        target_next    = target_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        first_idx_next = first_idx_reg;
        last_idx_next  = last_idx_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        lo_c           = lo_reg;
        hi_c           = hi_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop        = 1'b1;
                    m_valid_next   = 1'b1;
                    status_next    = ST_OK;
                    first_idx_next = '0;
                    last_idx_next  = '0;
                    unique case (cmd.kind)
                        CMD_APPEND: begin
                            if (count_reg < DEPTH_C) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                status_next = ST_FULL;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_QUERY: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOT_FOUND;
                            end else begin
                                m_valid_next = 1'b0;
                                target_next  = cmd.value;
                                lo_c         = '0;
                                hi_c         = count_reg - 1'b1;
                                lo_next      = lo_c;
                                hi_next      = hi_c;
                                if (lo_c < hi_c) begin
                                    mid_next   = mid_of(lo_c, hi_c);
                                    state_next = S_LOWER;
                                end else begin
                                    mid_next   = lo_c;
                                    state_next = S_CHECK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOWER: begin
                if (elem >= target_reg) begin
                    hi_c = mid_reg;
                end else begin
                    lo_c = mid_reg + 1'b1;
                end
                lo_next = lo_c;
                hi_next = hi_c;
                if (lo_c < hi_c) begin
                    mid_next = mid_of(lo_c, hi_c);
                end else begin
                    mid_next   = lo_c;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (elem != target_reg) begin
                    m_valid_next   = 1'b1;
                    status_next    = ST_NOT_FOUND;
                    first_idx_next = '0;
                    last_idx_next  = '0;
                    state_next     = S_IDLE;
                end else begin
                    first_next = lo_reg;
                    hi_c       = count_reg;
                    hi_next    = hi_c;
                    mid_next   = mid_of(lo_reg, hi_c);
                    state_next = S_UPPER;
                end
            end
            S_UPPER: begin
                if (elem <= target_reg) begin
                    lo_c = mid_reg + 1'b1;
                end else begin
                    hi_c = mid_reg;
                end
                lo_next = lo_c;
                hi_next = hi_c;
                if (lo_c < hi_c) begin
                    mid_next = mid_of(lo_c, hi_c);
                end else begin
                    m_valid_next   = 1'b1;
                    status_next    = ST_OK;
                    first_idx_next = to_index(first_reg);
                    last_idx_next  = to_index(lo_c - 1'b1);
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        first_reg     <= first_next;
        target_reg    <= target_next;
        status_reg    <= status_next;
        first_idx_reg <= first_idx_next;
        last_idx_reg  <= last_idx_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_first_index = first_idx_reg;
    assign m_last_index  = last_idx_reg;

endmodule
